/* rtl/rv32i_fetch_decode_assert.svh */
// ----------------------------------------------------------------------------
// rv32i_fetch_decode assertion macros
// Concurrent checks clocked on clk_i and held off during reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef RV32I_FETCH_DECODE_ASSERT_SVH
`define RV32I_FETCH_DECODE_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define FD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define FD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define FD_ASSERT(lbl, prop, msg)
`define FD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* rtl/rv32fd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32fd_pkg
// Operation codes, opcode constants and the result word type of the
// RV32I fetch and decode stage.
// ----------------------------------------------------------------------------
package rv32fd_pkg;

  localparam logic [31:0] EXIT_WORD = 32'h0ff0_0513;

  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;

  localparam logic [6:0] FUNCT7_BASE = 7'b0000000;
  localparam logic [6:0] FUNCT7_ALT  = 7'b0100000;

  typedef enum logic [5:0] {
    OP_LUI     = 6'd0,
    OP_AUIPC   = 6'd1,
    OP_JAL     = 6'd2,
    OP_JALR    = 6'd3,
    OP_BEQ     = 6'd4,
    OP_BNE     = 6'd5,
    OP_BLT     = 6'd6,
    OP_BGE     = 6'd7,
    OP_BLTU    = 6'd8,
    OP_BGEU    = 6'd9,
    OP_LB      = 6'd10,
    OP_LH      = 6'd11,
    OP_LW      = 6'd12,
    OP_LBU     = 6'd13,
    OP_LHU     = 6'd14,
    OP_SB      = 6'd15,
    OP_SH      = 6'd16,
    OP_SW      = 6'd17,
    OP_ADDI    = 6'd18,
    OP_SLTI    = 6'd19,
    OP_SLTIU   = 6'd20,
    OP_XORI    = 6'd21,
    OP_ORI     = 6'd22,
    OP_ANDI    = 6'd23,
    OP_SLLI    = 6'd24,
    OP_SRLI    = 6'd25,
    OP_SRAI    = 6'd26,
    OP_ADD     = 6'd27,
    OP_SUB     = 6'd28,
    OP_SLL     = 6'd29,
    OP_SLT     = 6'd30,
    OP_SLTU    = 6'd31,
    OP_XOR     = 6'd32,
    OP_SRL     = 6'd33,
    OP_SRA     = 6'd34,
    OP_OR      = 6'd35,
    OP_AND     = 6'd36,
    OP_EXIT    = 6'd37,
    OP_ILLEGAL = 6'd38
  } op_kind_e;

  typedef struct packed {
    op_kind_e    op_kind;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    logic [31:0] instr_addr;
    logic        predicted_taken;
    logic [31:0] jump_target;
    logic [31:0] mem_age;
  } res_t;

endpackage

/* rtl/rv32i_fetch_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_fetch_decode
// RV32I fetch and decode stage: program counter, decode, jump targets and
// load/store ordering.
// ----------------------------------------------------------------------------
// One instruction word is taken per clock cycle while in_stall_o is low;
// its decoded word is registered. Decode, the target adders and the
// next-pc choice sit in one combinational pass from the input ports into the
// program counter and the result register, so the next word is decoded
// against the updated pc with no bubble. A skid register behind the result
// register absorbs one word while the output is stalled; in_stall_o rises
// only once both are full. A flush word, a word seen while halted and a word
// flagged queue_full are taken but give no output word. The exit word halts
// fetch until the next flush.
// ----------------------------------------------------------------------------
`include "rv32i_fetch_decode_assert.svh"

module rv32i_fetch_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               flush_i,
  input  logic [31:0]        flush_target_i,
  input  logic [31:0]        instr_word_i,
  input  logic               predict_taken_i,
  input  logic               queue_full_i,
  input  logic [31:0]        jalr_base_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         op_kind_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic signed [31:0] immediate_o,
  output logic [31:0]        instr_addr_o,
  output logic               predicted_taken_o,
  output logic [31:0]        jump_target_o,
  output logic [31:0]        mem_age_o
);

  logic [31:0] pc_q, pc_d;
  logic        halted_q, halted_d;
  logic [31:0] mem_cnt_q, mem_cnt_d;

  logic        out_valid_q;
  logic        skid_valid_q;
  rv32fd_pkg::res_t out_q;
  rv32fd_pkg::res_t skid_q;
  rv32fd_pkg::res_t res;

  logic        in_acc;
  logic        emit;
  logic        out_free;

  logic [31:0] w;
  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [31:0] imm;
  logic [31:0] pc_tgt;
  logic [31:0] jalr_sum;
  logic [31:0] tgt;
  logic [31:0] nxt_pc;
  rv32fd_pkg::op_kind_e opk;
  logic        is_branch;
  logic        memop;
  logic        is_exit;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign emit       = in_acc & ~flush_i & ~halted_q & ~queue_full_i;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  assign w      = instr_word_i;
  assign opcode = w[6:0];
  assign f3     = w[14:12];
  assign f7     = w[31:25];

  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_u = {w[31:12], 12'b0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

  // Decode opcode, funct3 and funct7 into the dense operation code.
  always_comb begin
    opk       = rv32fd_pkg::OP_ILLEGAL;
    is_branch = 1'b0;
    memop     = 1'b0;
    case (opcode)
      rv32fd_pkg::OPC_LUI:   opk = rv32fd_pkg::OP_LUI;
      rv32fd_pkg::OPC_AUIPC: opk = rv32fd_pkg::OP_AUIPC;
      rv32fd_pkg::OPC_JAL:   opk = rv32fd_pkg::OP_JAL;
      rv32fd_pkg::OPC_JALR: begin
        if (f3 == 3'd0) opk = rv32fd_pkg::OP_JALR;
      end
      rv32fd_pkg::OPC_BRANCH: begin
        is_branch = 1'b1;
        case (f3)
          3'd0:    opk = rv32fd_pkg::OP_BEQ;
          3'd1:    opk = rv32fd_pkg::OP_BNE;
          3'd4:    opk = rv32fd_pkg::OP_BLT;
          3'd5:    opk = rv32fd_pkg::OP_BGE;
          3'd6:    opk = rv32fd_pkg::OP_BLTU;
          3'd7:    opk = rv32fd_pkg::OP_BGEU;
          default: is_branch = 1'b0;
        endcase
      end
      rv32fd_pkg::OPC_LOAD: begin
        memop = 1'b1;
        case (f3)
          3'd0:    opk = rv32fd_pkg::OP_LB;
          3'd1:    opk = rv32fd_pkg::OP_LH;
          3'd2:    opk = rv32fd_pkg::OP_LW;
          3'd4:    opk = rv32fd_pkg::OP_LBU;
          3'd5:    opk = rv32fd_pkg::OP_LHU;
          default: memop = 1'b0;
        endcase
      end
      rv32fd_pkg::OPC_STORE: begin
        memop = 1'b1;
        case (f3)
          3'd0:    opk = rv32fd_pkg::OP_SB;
          3'd1:    opk = rv32fd_pkg::OP_SH;
          3'd2:    opk = rv32fd_pkg::OP_SW;
          default: memop = 1'b0;
        endcase
      end
      rv32fd_pkg::OPC_OP_IMM: begin
        case (f3)
          3'd0: opk = rv32fd_pkg::OP_ADDI;
          3'd1: begin
            if (f7 == rv32fd_pkg::FUNCT7_BASE) opk = rv32fd_pkg::OP_SLLI;
          end
          3'd2: opk = rv32fd_pkg::OP_SLTI;
          3'd3: opk = rv32fd_pkg::OP_SLTIU;
          3'd4: opk = rv32fd_pkg::OP_XORI;
          3'd5: begin
            if (f7 == rv32fd_pkg::FUNCT7_BASE)     opk = rv32fd_pkg::OP_SRLI;
            else if (f7 == rv32fd_pkg::FUNCT7_ALT) opk = rv32fd_pkg::OP_SRAI;
          end
          3'd6:    opk = rv32fd_pkg::OP_ORI;
          default: opk = rv32fd_pkg::OP_ANDI;
        endcase
      end
      rv32fd_pkg::OPC_OP: begin
        if (f7 == rv32fd_pkg::FUNCT7_BASE) begin
          case (f3)
            3'd0:    opk = rv32fd_pkg::OP_ADD;
            3'd1:    opk = rv32fd_pkg::OP_SLL;
            3'd2:    opk = rv32fd_pkg::OP_SLT;
            3'd3:    opk = rv32fd_pkg::OP_SLTU;
            3'd4:    opk = rv32fd_pkg::OP_XOR;
            3'd5:    opk = rv32fd_pkg::OP_SRL;
            3'd6:    opk = rv32fd_pkg::OP_OR;
            default: opk = rv32fd_pkg::OP_AND;
          endcase
        end else if (f7 == rv32fd_pkg::FUNCT7_ALT) begin
          if (f3 == 3'd0)      opk = rv32fd_pkg::OP_SUB;
          else if (f3 == 3'd5) opk = rv32fd_pkg::OP_SRA;
        end
      end
      default: opk = rv32fd_pkg::OP_ILLEGAL;
    endcase
  end

  // Pick the immediate of the instruction format; zero for R-type and illegal.
  always_comb begin
    imm = '0;
    if (opk != rv32fd_pkg::OP_ILLEGAL) begin
      case (opcode)
        rv32fd_pkg::OPC_LUI,
        rv32fd_pkg::OPC_AUIPC:  imm = imm_u;
        rv32fd_pkg::OPC_JAL:    imm = imm_j;
        rv32fd_pkg::OPC_BRANCH: imm = imm_b;
        rv32fd_pkg::OPC_STORE:  imm = imm_s;
        rv32fd_pkg::OPC_JALR,
        rv32fd_pkg::OPC_LOAD,
        rv32fd_pkg::OPC_OP_IMM: imm = imm_i;
        default:                imm = '0;
      endcase
    end
  end

  assign is_exit  = (w == rv32fd_pkg::EXIT_WORD);
  assign pc_tgt   = pc_q + imm;
  assign jalr_sum = jalr_base_i + imm;

  always_comb begin
    tgt    = '0;
    nxt_pc = pc_q + 32'd4;
    if (opk == rv32fd_pkg::OP_JAL) begin
      tgt    = pc_tgt;
      nxt_pc = pc_tgt;
    end else if (opk == rv32fd_pkg::OP_JALR) begin
      tgt    = {jalr_sum[31:1], 1'b0};
      nxt_pc = {jalr_sum[31:1], 1'b0};
    end else if (is_branch && predict_taken_i) begin
      tgt    = pc_tgt;
      nxt_pc = pc_tgt;
    end
  end

  always_comb begin
    res.op_kind         = is_exit ? rv32fd_pkg::OP_EXIT : opk;
    res.dest_reg        = w[11:7];
    res.src1_reg        = w[19:15];
    res.src2_reg        = w[24:20];
    res.immediate       = imm;
    res.instr_addr      = pc_q;
    res.predicted_taken = predict_taken_i;
    res.jump_target     = tgt;
    res.mem_age         = memop ? mem_cnt_q : 32'd0;
  end

  always_comb begin
    pc_d      = pc_q;
    halted_d  = halted_q;
    mem_cnt_d = mem_cnt_q;
    if (in_acc && flush_i) begin
      pc_d     = flush_target_i;
      halted_d = 1'b0;
    end else if (emit) begin
      pc_d = nxt_pc;
      if (is_exit) halted_d = 1'b1;
      if (memop)   mem_cnt_d = mem_cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= '0;
      halted_q     <= 1'b0;
      mem_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      halted_q  <= halted_d;
      mem_cnt_q <= mem_cnt_d;
      if (out_free) begin
        // Drain the skid word first; no new word arrives while it is full.
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= emit;
        end
      end else if (emit) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (emit)    out_q <= res;
    end else if (emit) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign op_kind_o         = out_q.op_kind;
  assign dest_reg_o        = out_q.dest_reg;
  assign src1_reg_o        = out_q.src1_reg;
  assign src2_reg_o        = out_q.src2_reg;
  assign immediate_o       = signed'(out_q.immediate);
  assign instr_addr_o      = out_q.instr_addr;
  assign predicted_taken_o = out_q.predicted_taken;
  assign jump_target_o     = out_q.jump_target;
  assign mem_age_o         = out_q.mem_age;

  `FD_ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q, "skid word without output word")
  `FD_ASSERT(a_halt_holds_pc, (in_acc && halted_q && !flush_i) |=> $stable(pc_q), "pc moved while halted")
  `FD_ASSERT(a_exit_halts, (emit && is_exit) |=> halted_q, "exit word did not halt fetch")
  `FD_ASSERT(a_age_steps, (emit && memop) |=> (mem_cnt_q == $past(mem_cnt_q) + 32'd1), "age count did not advance")

endmodule
